### src/abln_pkg.sv
// Shared types and constants for the average level block normalizer.
// No dependencies; the other files but abln_ram refer to it by scoped names.
package abln_pkg;

   // Block storage geometry
   localparam int BLOCK_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(BLOCK_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;

   // Sample and statistics widths
   localparam int SAMPLE_W = 16;
   localparam int MAG_W    = SAMPLE_W + 1;
   localparam int SUM_W    = ADDR_W + SAMPLE_W;
   localparam int CHAN_W   = 4;
   // level stays at or below 32768 * (2 * 15 - 1), which needs 20 bits
   localparam int LEVEL_W  = 20;
   localparam int PROD_W   = 31;

   // Shared divider geometry
   localparam int DIV_NUM_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int DIV_DEN_W = LEVEL_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   localparam logic [CHAN_W-1:0]   CHAN_RESET     = CHAN_W'(2);
   localparam logic [SAMPLE_W-1:0] PEAK_LIMIT     = SAMPLE_W'(32767);
   localparam logic [14:0]         PEAK_LIMIT_MAG = 15'd32767;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FRAMES_START,
      ST_FRAMES_WAIT,
      ST_LEVEL_START,
      ST_LEVEL_WAIT,
      ST_FETCH_READ,
      ST_FETCH_DIV,
      ST_FETCH_WAIT,
      ST_FETCH_OUT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic load_step;
      logic read_issue;
      logic frames_start;
      logic frames_take;
      logic level_start;
      logic level_take;
      logic mult_take;
      logic scale_start;
      logic out_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic item_load;
      logic item_last;
      logic fetch_avail;
      logic use_div;
      logic div_done;
      logic out_busy;
   } status_type;

endpackage

### src/abln_req_if.sv
// Input channel of the normalizer: valid/ready handshake plus one item.
// Depends on abln_pkg for the sample width.
interface abln_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  operation;
   logic signed [abln_pkg::SAMPLE_W-1:0]  sample_in;
   logic                                  block_end;

   modport source (output valid, output operation, output sample_in, output block_end,
                   input ready);
   modport sink   (input valid, input operation, input sample_in, input block_end,
                   output ready);
endinterface

### src/abln_rsp_if.sv
// Result channel of the normalizer: valid/ready handshake plus one item.
// Depends on abln_pkg for the sample width.
interface abln_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [abln_pkg::SAMPLE_W-1:0]  sample_out;
   logic                                  was_scaled;
   logic                                  final_sample;

   modport source (output valid, output sample_out, output was_scaled,
                   output final_sample, input ready);
   modport sink   (input valid, input sample_out, input was_scaled,
                   input final_sample, output ready);
endinterface

### src/abln_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module abln_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/abln_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on abln_pkg for operand widths.
module abln_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [abln_pkg::DIV_NUM_W-1:0] numer,
   input  logic [abln_pkg::DIV_DEN_W-1:0] denom,
   output logic                           done,
   output logic [abln_pkg::DIV_NUM_W-1:0] quotient
);

   logic [abln_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [abln_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [abln_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [abln_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [abln_pkg::DIV_DEN_W:0]   trial;
   logic [abln_pkg::DIV_DEN_W:0]   diff;
   logic                           fits;

   // one shift and subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[abln_pkg::DIV_NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
         cnt_in  = abln_pkg::DIV_CNT_W'(abln_pkg::DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[abln_pkg::DIV_DEN_W-1:0] : trial[abln_pkg::DIV_DEN_W-1:0];
         quo_in = {quo_ff[abln_pkg::DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == abln_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands and partial results
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### src/abln_datapath.sv
// Datapath: item latch, block store, statistics, scaling and result register.
// Depends on abln_pkg, abln_rsp_if, abln_ram and abln_div.
module abln_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [abln_pkg::CHAN_W-1:0]          csr_write_data,
   input  logic                                 item_operation,
   input  logic signed [abln_pkg::SAMPLE_W-1:0] item_sample,
   input  logic                                 item_block_end,
   input  abln_pkg::cmd_type                    cmd,
   output abln_pkg::status_type                 status,
   abln_rsp_if.source                           rsp
);

   // latched item
   logic                                 op_ff;
   logic signed [abln_pkg::SAMPLE_W-1:0] smp_ff;
   logic                                 last_ff;

   // configuration and block state
   logic [abln_pkg::CHAN_W-1:0]          chan_ff, chan_in;
   logic [abln_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [abln_pkg::COUNT_W-1:0]         fptr_ff, fptr_in;
   logic signed [abln_pkg::SAMPLE_W-1:0] high_ff, high_in;
   logic signed [abln_pkg::SAMPLE_W-1:0] low_ff, low_in;
   logic [abln_pkg::SUM_W-1:0]           sum_ff, sum_in;
   logic [abln_pkg::LEVEL_W-1:0]         level_ff, level_in;
   logic [abln_pkg::COUNT_W-1:0]         frames_ff, frames_in;
   logic                                 scale_ff, scale_in;
   logic                                 ready_ff, ready_in;

   // fetch pipeline
   logic [abln_pkg::SAMPLE_W-1:0]        raw_ff;
   logic [abln_pkg::PROD_W-1:0]          prod_ff;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [abln_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                                 rsp_scaled_ff, rsp_scaled_in;
   logic                                 rsp_final_ff, rsp_final_in;

   // combinational helpers
   logic [abln_pkg::COUNT_W-1:0]         base_count;
   logic signed [abln_pkg::SAMPLE_W-1:0] base_high, base_low;
   logic [abln_pkg::SUM_W-1:0]           base_sum;
   logic                                 room;
   logic signed [abln_pkg::MAG_W-1:0]    smp_ext;
   logic [abln_pkg::MAG_W-1:0]           smp_mag;
   logic [abln_pkg::SAMPLE_W-1:0]        rd_data;
   logic signed [abln_pkg::MAG_W-1:0]    rd_ext;
   logic [abln_pkg::MAG_W-1:0]           rd_mag;
   logic [abln_pkg::CHAN_W-1:0]          chan_eff;
   logic                                 div_start;
   logic [abln_pkg::DIV_NUM_W-1:0]       div_numer;
   logic [abln_pkg::DIV_DEN_W-1:0]       div_denom;
   logic                                 div_done;
   logic [abln_pkg::DIV_NUM_W-1:0]       div_quo;
   logic [14:0]                          q_sat;
   logic [abln_pkg::SAMPLE_W-1:0]        scaled_mag;
   logic                                 out_busy;

   // block store
   abln_ram #(
      .WIDTH (abln_pkg::SAMPLE_W),
      .DEPTH (abln_pkg::BLOCK_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load_step && room),
      .wr_addr (base_count[abln_pkg::ADDR_W-1:0]),
      .wr_data (smp_ff),
      .rd_en   (cmd.read_issue),
      .rd_addr (fptr_ff[abln_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // shared divider: frame count, level and per-sample scale
   always_comb begin
      div_start = cmd.frames_start || cmd.level_start || cmd.scale_start;
      div_numer = abln_pkg::DIV_NUM_W'(prod_ff);
      div_denom = level_ff;
      if (cmd.frames_start) begin
         div_numer = abln_pkg::DIV_NUM_W'(count_ff);
         div_denom = abln_pkg::DIV_DEN_W'(chan_eff);
      end else if (cmd.level_start) begin
         div_numer = abln_pkg::DIV_NUM_W'(sum_ff);
         div_denom = abln_pkg::DIV_DEN_W'(frames_ff);
      end
   end

   abln_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_quo)
   );

   // magnitudes and the start point of a load
   always_comb begin
      chan_eff   = (chan_ff == '0) ? abln_pkg::CHAN_W'(1) : chan_ff;
      smp_ext    = abln_pkg::MAG_W'(smp_ff);
      smp_mag    = smp_ext[abln_pkg::MAG_W-1] ? abln_pkg::MAG_W'(-smp_ext)
                                              : abln_pkg::MAG_W'(smp_ext);
      rd_ext     = abln_pkg::MAG_W'(signed'(rd_data));
      rd_mag     = rd_ext[abln_pkg::MAG_W-1] ? abln_pkg::MAG_W'(-rd_ext)
                                             : abln_pkg::MAG_W'(rd_ext);
      base_count = ready_ff ? '0 : count_ff;
      base_high  = ready_ff ? '0 : high_ff;
      base_low   = ready_ff ? '0 : low_ff;
      base_sum   = ready_ff ? '0 : sum_ff;
      room       = (base_count < abln_pkg::COUNT_W'(abln_pkg::BLOCK_DEPTH));
      q_sat      = (div_quo > abln_pkg::DIV_NUM_W'(abln_pkg::PEAK_LIMIT_MAG))
                   ? abln_pkg::PEAK_LIMIT_MAG : div_quo[14:0];
      if (!ready_ff && level_ff == '0) begin
         scaled_mag = '0;
      end else if (level_ff == '0) begin
         scaled_mag = (raw_ff == '0) ? '0 : abln_pkg::PEAK_LIMIT;
      end else begin
         scaled_mag = abln_pkg::SAMPLE_W'(q_sat);
      end
      out_busy = rsp_valid_ff && !rsp.ready;
   end

   // next block state
   always_comb begin
      chan_in   = chan_ff;
      count_in  = count_ff;
      fptr_in   = fptr_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      sum_in    = sum_ff;
      level_in  = level_ff;
      frames_in = frames_ff;
      scale_in  = scale_ff;
      ready_in  = ready_ff;
      if (csr_write_enable) begin
         chan_in = csr_write_data;
      end
      if (cmd.load_step) begin
         count_in = base_count;
         high_in  = base_high;
         low_in   = base_low;
         sum_in   = base_sum;
         if (ready_ff) begin
            fptr_in  = '0;
            level_in = '0;
            scale_in = 1'b0;
            ready_in = 1'b0;
         end
         if (room) begin
            count_in = base_count + 1'b1;
            high_in  = (smp_ff > base_high) ? smp_ff : base_high;
            low_in   = (smp_ff < base_low) ? smp_ff : base_low;
            sum_in   = base_sum + abln_pkg::SUM_W'(smp_mag);
         end
      end
      if (cmd.frames_take) begin
         frames_in = (div_quo == '0) ? abln_pkg::COUNT_W'(1)
                                     : div_quo[abln_pkg::COUNT_W-1:0];
      end
      if (cmd.level_take) begin
         level_in = div_quo[abln_pkg::LEVEL_W-1:0];
         scale_in = (high_ff < signed'(abln_pkg::PEAK_LIMIT)) &&
                    (low_ff > -signed'(abln_pkg::PEAK_LIMIT));
         ready_in = 1'b1;
         fptr_in  = '0;
      end
      if (cmd.out_load) begin
         fptr_in = fptr_ff + 1'b1;
      end
   end

   // next result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_final_in  = rsp_final_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_scaled_in = scale_ff;
         rsp_final_in  = ((fptr_ff + 1'b1) == count_ff);
         if (!scale_ff) begin
            rsp_sample_in = signed'(raw_ff);
         end else if (raw_ff[abln_pkg::SAMPLE_W-1]) begin
            rsp_sample_in = -signed'(scaled_mag);
         end else begin
            rsp_sample_in = signed'(scaled_mag);
         end
      end
   end

   // control and block state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= abln_pkg::CHAN_RESET;
         count_ff     <= '0;
         fptr_ff      <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         sum_ff       <= '0;
         level_ff     <= '0;
         frames_ff    <= abln_pkg::COUNT_W'(1);
         scale_ff     <= 1'b0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chan_ff      <= chan_in;
         count_ff     <= count_in;
         fptr_ff      <= fptr_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         sum_ff       <= sum_in;
         level_ff     <= level_in;
         frames_ff    <= frames_in;
         scale_ff     <= scale_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= item_operation;
         smp_ff  <= item_sample;
         last_ff <= item_block_end;
      end
      if (cmd.mult_take) begin
         raw_ff  <= rd_data;
         prod_ff <= abln_pkg::PROD_W'(rd_mag) * abln_pkg::PROD_W'(abln_pkg::PEAK_LIMIT);
      end
      rsp_sample_ff <= rsp_sample_in;
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_final_ff  <= rsp_final_in;
   end

   // status to the controller
   always_comb begin
      status.item_load   = (op_ff == abln_pkg::OP_LOAD);
      status.item_last   = last_ff;
      status.fetch_avail = ready_ff && (fptr_ff < count_ff);
      status.use_div     = scale_ff && (level_ff != '0);
      status.div_done    = div_done;
      status.out_busy    = out_busy;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sample_out   = rsp_sample_ff;
   assign rsp.was_scaled   = rsp_scaled_ff;
   assign rsp.final_sample = rsp_final_ff;

`ifndef SYNTHESIS
   a_fptr_bound: assert property (@(posedge clock) disable iff (reset)
      fptr_ff <= count_ff)
      else $error("fetch pointer passed item count");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= abln_pkg::COUNT_W'(abln_pkg::BLOCK_DEPTH))
      else $error("item count beyond block depth");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp.ready))
      else $error("result register overwritten while held");
   a_scale_div: assert property (@(posedge clock) disable iff (reset)
      cmd.scale_start |-> (level_ff != '0) && scale_ff)
      else $error("scale division started without a usable level");
   a_out_in_block: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> ready_ff && (fptr_ff < count_ff))
      else $error("result produced outside a closed block");
`endif

endmodule

### src/abln_ctrl.sv
// Controller: sequences load, block close and fetch steps of the datapath.
// Depends on abln_pkg for the state, command and status types.
module abln_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  abln_pkg::status_type status,
   output abln_pkg::cmd_type    cmd
);

   abln_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abln_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         abln_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = abln_pkg::ST_DECODE;
            end
         end
         abln_pkg::ST_DECODE: begin
            if (status.item_load) begin
               cmd.load_step = 1'b1;
               state_in = status.item_last ? abln_pkg::ST_FRAMES_START : abln_pkg::ST_IDLE;
            end else if (status.fetch_avail) begin
               cmd.read_issue = 1'b1;
               state_in       = abln_pkg::ST_FETCH_READ;
            end else begin
               state_in = abln_pkg::ST_IDLE;
            end
         end
         abln_pkg::ST_FRAMES_START: begin
            cmd.frames_start = 1'b1;
            state_in         = abln_pkg::ST_FRAMES_WAIT;
         end
         abln_pkg::ST_FRAMES_WAIT: begin
            if (status.div_done) begin
               cmd.frames_take = 1'b1;
               state_in        = abln_pkg::ST_LEVEL_START;
            end
         end
         abln_pkg::ST_LEVEL_START: begin
            cmd.level_start = 1'b1;
            state_in        = abln_pkg::ST_LEVEL_WAIT;
         end
         abln_pkg::ST_LEVEL_WAIT: begin
            if (status.div_done) begin
               cmd.level_take = 1'b1;
               state_in       = abln_pkg::ST_IDLE;
            end
         end
         abln_pkg::ST_FETCH_READ: begin
            cmd.mult_take = 1'b1;
            state_in      = abln_pkg::ST_FETCH_DIV;
         end
         abln_pkg::ST_FETCH_DIV: begin
            if (status.use_div) begin
               cmd.scale_start = 1'b1;
               state_in        = abln_pkg::ST_FETCH_WAIT;
            end else begin
               state_in = abln_pkg::ST_FETCH_OUT;
            end
         end
         abln_pkg::ST_FETCH_WAIT: begin
            if (status.div_done) begin
               state_in = abln_pkg::ST_FETCH_OUT;
            end
         end
         abln_pkg::ST_FETCH_OUT: begin
            // hold until the result register is free
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = abln_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abln_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_one_div: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.frames_start, cmd.level_start, cmd.scale_start}))
      else $error("two divisions started at once");
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == abln_pkg::ST_DECODE)
      else $error("captured item not decoded");
   a_wait_done: assert property (@(posedge clock) disable iff (reset)
      cmd.scale_start |=> state_ff == abln_pkg::ST_FETCH_WAIT)
      else $error("scale division started outside the fetch sequence");
`endif

endmodule

### src/average_level_block_normalizer.sv
// Top level of the average level block normalizer: controller plus datapath.
// Depends on abln_pkg, abln_req_if, abln_rsp_if, abln_ctrl and abln_datapath.
//
//   channel   direction  handshake              payload
//   req       in         req.valid/req.ready    operation, sample_in, block_end
//   rsp       out        rsp.valid/rsp.ready    sample_out, was_scaled, final_sample
//   csr       in         csr_write_enable       csr_write_data (channel_count)
//
// One item at a time. A load is captured and then decoded; the load that closes a block
// then makes two 31-step passes of the shared divider (frame count, then level).
// A fetch does a store read and a multiply and, when the block is scaled with a
// nonzero level, one 31-step division in the shared divider.
// Reset is synchronous; the block store needs no clearing pass. A fetch stalls in its
// last step only while the previous result still waits in the result register.
module average_level_block_normalizer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [abln_pkg::CHAN_W-1:0] csr_write_data,
   abln_req_if.sink                    req,
   abln_rsp_if.source                  rsp
);

   abln_pkg::cmd_type    cmd;
   abln_pkg::status_type status;
   logic                 ctrl_ready;

   abln_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req.ready = ctrl_ready;

   abln_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_operation   (req.operation),
      .item_sample      (req.sample_in),
      .item_block_end   (req.block_end),
      .cmd              (cmd),
      .status           (status),
      .rsp              (rsp)
   );

endmodule
